/* rtl/sirt_pkg.sv */
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types, constants and the digit-to-ASCII function for the signed
// integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(VALUE_WIDTH);
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;

	localparam logic [DIGIT_W-1:0] RADIX_MIN  = 6'd2;
	localparam logic [DIGIT_W-1:0] RADIX_MAX  = 6'd36;
	localparam logic [CHAR_W-1:0]  MINUS_CHAR = 7'h2D;
	localparam logic [CHAR_W-1:0]  ZERO_CHAR  = 7'h30;
	localparam logic [CHAR_W-1:0]  ALPHA_CHAR = 7'h61;
	localparam logic [CHAR_W-1:0]  EMPTY_CHAR = 7'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [DIGIT_W-1:0]     divisor;
	} div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [DIGIT_W-1:0]     remainder;
	} div_rsp_t;

	// digit value 0..35 to '0'-'9' or 'a'-'z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < 6'd10) begin
			digit_char = ZERO_CHAR + dx;
		end else begin
			digit_char = ALPHA_CHAR + dx - 7'd10;
		end
	endfunction

endpackage

/* rtl/sirt_divider.sv */
// ----------------------------------------------------------------------------
// sirt_divider
// Restoring radix-2 divider: one quotient bit per cycle,
// small divisor (the radix).
// ----------------------------------------------------------------------------
module sirt_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  sirt_pkg::div_req_t req,
	output sirt_pkg::div_rsp_t rsp
);
	import sirt_pkg::*;

	logic [VALUE_WIDTH-1:0] quot_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [DIGIT_W-1:0]     divisor_q;
	logic [IDX_W-1:0]       bit_cnt_q;
	logic                   run_q;
	logic                   done_q;

	logic [DIGIT_W:0]       trial;
	logic                   fits;
	logic [DIGIT_W:0]       trial_diff;

	// one shift-and-subtract step
	always_comb begin
		trial      = {rem_q, quot_q[VALUE_WIDTH-1]};
		fits       = (trial >= {1'b0, divisor_q});
		trial_diff = trial - {1'b0, divisor_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q     <= 1'b1;
				bit_cnt_q <= '0;
			end else if (run_q) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
				if (bit_cnt_q == IDX_W'(VALUE_WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[VALUE_WIDTH-2:0], fits};
			rem_q  <= fits ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/sirt_digit_stack.sv */
// ----------------------------------------------------------------------------
// sirt_digit_stack
// Holds the remainder digits as they are produced, least significant first,
// so they can be read back most significant first. The read is registered;
// a digit written at the address being read is passed straight through.
// ----------------------------------------------------------------------------
module sirt_digit_stack (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [sirt_pkg::IDX_W-1:0]    wr_addr,
	input  logic [sirt_pkg::DIGIT_W-1:0]  wr_data,
	input  logic [sirt_pkg::IDX_W-1:0]    rd_addr,
	output logic [sirt_pkg::DIGIT_W-1:0]  rd_data
);
	import sirt_pkg::*;

	logic [DIGIT_W-1:0] digits_q [VALUE_WIDTH];
	logic [DIGIT_W-1:0] rd_data_q;

	// digit write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digits_q[wr_addr] <= wr_data;
		end
	end

	// digit read, write-through on a matching address
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= digits_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/signed_integer_to_radix_text_top.sv */
// The first character leaves once every digit has been divided out; the run then
// gives one character per cycle. A new value is taken only while idle, once the
// last one is through; the pace is set by the bit-serial divider, one quotient
// bit a cycle.
// An invalid radix gives its single empty word the cycle after start.
// Reset: arst_n clears the sequencer and strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Converts a signed value to ASCII text in radix 2..36, one character word
// per strobe, most significant first, with a leading '-' when negative.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [31:0]                   value,
	input  logic [5:0]                           base,
	output logic                                 busy,
	output logic                                 strobe,
	output logic [sirt_pkg::CHAR_W-1:0]          character,
	output logic                                 is_last,
	output logic                                 is_empty
);
	import sirt_pkg::*;

	state_t state_q, state_d;

	logic [DIGIT_W-1:0] base_q;
	logic               neg_q;
	logic [CNT_W-1:0]   count_q, count_d;

	logic               strobe_q, strobe_d;
	logic [CHAR_W-1:0]  character_q, character_d;
	logic               is_last_q, is_last_d;
	logic               is_empty_q, is_empty_d;

	logic [VALUE_WIDTH-1:0] raw;
	logic                   raw_neg;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic                   radix_ok;
	logic                   accept;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               push;
	logic [IDX_W-1:0]   rd_addr;
	logic [DIGIT_W-1:0] rd_digit;

	// input decode
	always_comb begin
		raw       = VALUE_WIDTH'(value);
		raw_neg   = raw[VALUE_WIDTH-1];
		magnitude = raw_neg ? (~raw + 1'b1) : raw;
		radix_ok  = base inside {[RADIX_MIN:RADIX_MAX]};
		accept    = start && (state_q == ST_IDLE);
	end

	// shared divider
	sirt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// digit storage: fetch the digit that the next cycle emits
	assign rd_addr = count_d[IDX_W-1:0] - 1'b1;

	sirt_digit_stack u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (div_rsp.remainder),
		.rd_addr (rd_addr),
		.rd_data (rd_digit)
	);

	// sequencer: next state and output word
	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		strobe_d         = 1'b0;
		character_d      = character_q;
		is_last_d        = is_last_q;
		is_empty_d       = 1'b0;
		push             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = div_rsp.quotient;
		div_req.divisor  = base_q;
		case (state_q)
			ST_IDLE: begin
				div_req.dividend = magnitude;
				div_req.divisor  = base;
				count_d          = '0;
				if (accept) begin
					if (radix_ok) begin
						div_req.start = 1'b1;
						state_d       = ST_DIVIDE;
					end else begin
						strobe_d    = 1'b1;
						character_d = EMPTY_CHAR;
						is_last_d   = 1'b1;
						is_empty_d  = 1'b1;
					end
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					push    = 1'b1;
					count_d = count_q + 1'b1;
					if (div_rsp.quotient != '0) begin
						div_req.start = 1'b1;
					end else begin
						state_d = neg_q ? ST_SIGN : ST_EMIT;
					end
				end
			end
			ST_SIGN: begin
				strobe_d    = 1'b1;
				character_d = MINUS_CHAR;
				is_last_d   = 1'b0;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				count_d     = count_q - 1'b1;
				strobe_d    = 1'b1;
				character_d = digit_char(rd_digit);
				is_last_d   = (count_q == CNT_W'(1));
				if (count_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		character_q <= character_d;
		is_last_q   <= is_last_d;
		is_empty_q  <= is_empty_d;
		if (accept) begin
			base_q <= base;
			neg_q  <= raw_neg;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign is_last   = is_last_q;
	assign is_empty  = is_empty_q;

`ifndef SYNTHESIS
	// an empty word is a lone, blank, final word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_empty |-> is_last && (character == EMPTY_CHAR))
		else $error("empty word not marked last or not blank");

	// the final word hands the block back to idle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_last |-> !busy)
		else $error("busy after final word");

	// emission never starts from an empty stack
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count_q != '0) && (count_q <= CNT_W'(VALUE_WIDTH)))
		else $error("digit count out of range while emitting");

	// a digit is pushed only while dividing
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside divide state");
`endif

endmodule
